@@ rtl/ksel_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and link types for the k-smallest selector.
// Depends on nothing; used by ksel_cell and k_smallest_selector.
package ksel_pkg;

    localparam int MAX_K  = 16;
    localparam int VAL_W  = 32;
    localparam int KCFG_W = 5;
    localparam int KW     = $clog2(MAX_K + 1);
    localparam int CMP_W  = (KW > KCFG_W) ? KW : KCFG_W;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic                    ins;
        logic                    drain;
        logic signed [VAL_W-1:0] value;
    } t_ctl;

    // Link from a cell to its right-hand neighbour, used during insertion.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    occ;
        logic                    le;
    } t_fwd;

    // Link from a cell to its left-hand neighbour, used while draining.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    occ;
    } t_bwd;

endpackage

@@ rtl/k_smallest_selector.sv @@
`timescale 1ns / 1ps
// k_smallest_selector: keeps the K smallest signed values of a run, emits them ascending.
// Throughput: one input transfer per cycle while collecting, inserted as it is taken.
// A last item is inserted as it is taken; the chain then shifts one value towards the
// output register per output transfer, and input stalls until the drain has ended.
// Reset (synchronous, active low) empties the chain, clears o_out_valid and sets K to 1.
// Depends on ksel_pkg and ksel_cell.
module k_smallest_selector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel: the K register.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ksel_pkg::KCFG_W-1:0]       i_cfg_data,
    // Input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [ksel_pkg::VAL_W-1:0] i_value,
    input  logic                              i_last_item,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [ksel_pkg::VAL_W-1:0] o_result_value,
    output logic                              o_final_result
);

    // The block either collects values (every cycle a transfer may insert one)
    // or drains the chain after a last item, one value per output transfer.
    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state                            r_state;
    logic [ksel_pkg::KCFG_W-1:0]       r_k;
    logic                              r_out_valid;
    logic signed [ksel_pkg::VAL_W-1:0] r_out_value;
    logic                              r_out_final;

    logic [ksel_pkg::KW-1:0]           w_limit;
    logic [ksel_pkg::MAX_K-1:0]        w_lim;
    logic [ksel_pkg::MAX_K-1:0]        w_occ;
    logic                              w_in_acc;
    logic                              w_load;
    ksel_pkg::t_ctl                    w_ctl;
    ksel_pkg::t_fwd                    w_fwd [0:ksel_pkg::MAX_K];
    ksel_pkg::t_bwd                    w_bwd [0:ksel_pkg::MAX_K];

    // The config register is always writable; the user must make writes only while idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= ksel_pkg::KCFG_W'(1);
        end else if (i_cfg_valid) begin
            r_k <= i_cfg_data;
        end
    end

    // K above the chain length is clamped to the chain length.
    always_comb begin
        if (ksel_pkg::CMP_W'(r_k) > ksel_pkg::CMP_W'(ksel_pkg::MAX_K)) begin
            w_limit = ksel_pkg::KW'(ksel_pkg::MAX_K);
        end else begin
            w_limit = ksel_pkg::KW'(r_k);
        end
    end

    assign o_in_ready = (r_state == ST_RUN);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // During a drain, an occupied head cell's value moves into the output register whenever
    // that register is free or being emptied by a transfer in the same cycle.
    assign w_load = (r_state == ST_DRAIN) && w_bwd[0].occ && (!r_out_valid || i_out_ready);

    assign w_ctl.ins   = w_in_acc;
    assign w_ctl.drain = w_load;
    assign w_ctl.value = i_value;

    // The left end of the chain acts as a neighbour that is always "not larger",
    // so the head cell takes the new value when it is empty or its own value is larger.
    assign w_fwd[0].value           = '0;
    assign w_fwd[0].occ             = 1'b0;
    assign w_fwd[0].le              = 1'b1;
    assign w_bwd[ksel_pkg::MAX_K].value = '0;
    assign w_bwd[ksel_pkg::MAX_K].occ   = 1'b0;

    for (genvar i = 0; i < ksel_pkg::MAX_K; i++) begin : g_cell
        assign w_lim[i] = (ksel_pkg::KW'(i) < w_limit);
        assign w_occ[i] = w_bwd[i].occ;

        ksel_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_lim   (w_lim[i]),
            .i_fwd   (w_fwd[i]),
            .i_bwd   (w_bwd[i+1]),
            .o_fwd   (w_fwd[i+1]),
            .o_bwd   (w_bwd[i])
        );
    end

    // State and output register. A last item is inserted in the cycle it is
    // taken; the drain then runs until the head cell is empty, which also
    // leaves the chain empty for the next run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_RUN: begin
                    if (w_in_acc && i_last_item) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!w_bwd[0].occ) begin
                        r_state <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_load) begin
            r_out_value <= w_bwd[0].value;
            r_out_final <= !w_bwd[1].occ;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_final_result = r_out_final;

    // Occupied cells always form a block starting at the head of the chain.
    a_occ_contiguous : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ & (w_occ + ksel_pkg::MAX_K'(1))) == '0))
        else $error("kept values are not packed at the head of the chain");

    // A last item always starts a drain.
    a_last_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last_item) |=> (r_state == ST_DRAIN))
        else $error("last item did not start a drain");

    // Emitting the final value of a run leaves the chain empty.
    a_final_empties : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_bwd[1].occ) |=> (w_occ == '0))
        else $error("chain not empty after the final value of a run");

endmodule

@@ rtl/ksel_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sorted insertion chain: a kept value and its occupancy flag.
// Depends on ksel_pkg.
module ksel_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ksel_pkg::t_ctl  i_ctl,
    input  logic            i_lim,
    input  ksel_pkg::t_fwd  i_fwd,
    input  ksel_pkg::t_bwd  i_bwd,
    output ksel_pkg::t_fwd  o_fwd,
    output ksel_pkg::t_bwd  o_bwd
);

    logic signed [ksel_pkg::VAL_W-1:0] r_value;
    logic signed [ksel_pkg::VAL_W-1:0] n_value;
    logic                              r_occ;
    logic                              n_occ;
    logic                              w_occ_eff;
    logic                              w_le;

    // A slot beyond the current limit counts as empty.
    assign w_occ_eff = r_occ & i_lim;
    assign w_le      = w_occ_eff && (r_value <= i_ctl.value);

    always_comb begin
        n_value = r_value;
        n_occ   = r_occ;
        if (i_ctl.ins) begin
            if (w_le) begin
                n_occ = w_occ_eff;
            end else if (i_fwd.le) begin
                n_value = i_ctl.value;
                n_occ   = i_lim;
            end else begin
                n_value = i_fwd.value;
                n_occ   = i_fwd.occ & i_lim;
            end
        end else if (i_ctl.drain) begin
            n_value = i_bwd.value;
            n_occ   = i_bwd.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
        r_value <= n_value;
    end

    assign o_fwd.value = r_value;
    assign o_fwd.occ   = w_occ_eff;
    assign o_fwd.le    = w_le;
    assign o_bwd.value = r_value;
    assign o_bwd.occ   = r_occ;

endmodule
